>>> src/reply_replay_cache_top_defines.svh
// ----------------------------------------------------------------------------
// reply replay cache assertion macros
// shared property forms for the concurrent checks of the top level
// ----------------------------------------------------------------------------
`ifndef REPLY_REPLAY_CACHE_TOP_DEFINES_SVH
`define REPLY_REPLAY_CACHE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RRC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrc check failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define RRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrc check failed: next-cycle implication");

`endif

>>> src/rrc_pkg.sv
// ----------------------------------------------------------------------------
// rrc_pkg
// types and constants shared by the reply replay cache modules
// ----------------------------------------------------------------------------
package rrc_pkg;

  localparam int OPCODE_W = 2;
  localparam int ID_W     = 16;
  localparam int CMD_W    = 8;
  localparam int SIZE_W   = 16;
  localparam int SLOT_W   = 4;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  // one stored entry of the reply table
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [CMD_W-1:0]  cmd;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // one result beat
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [SIZE_W-1:0] found_size;
    logic              evicted;
  } result_t;

endpackage

>>> src/rrc_ram.sv
// ----------------------------------------------------------------------------
// rrc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/rrc_seq.sv
// ----------------------------------------------------------------------------
// rrc_seq
// sequencer: fifo pointers, insert/clear updates and the oldest-first scan
// ----------------------------------------------------------------------------
module rrc_seq #(
  parameter int CACHE_DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [rrc_pkg::OPCODE_W-1:0]          in_opcode,
  input  logic [rrc_pkg::ID_W-1:0]              in_request_id,
  input  logic [rrc_pkg::CMD_W-1:0]             in_command_byte,
  input  logic [rrc_pkg::SIZE_W-1:0]            in_reply_size,
  output logic                                  ram_wr_en,
  output logic [$clog2(CACHE_DEPTH)-1:0]        ram_wr_addr,
  output logic [$bits(rrc_pkg::entry_t)-1:0]    ram_wr_data,
  output logic                                  ram_rd_en,
  output logic [$clog2(CACHE_DEPTH)-1:0]        ram_rd_addr,
  input  logic [$bits(rrc_pkg::entry_t)-1:0]    ram_rd_data,
  output logic                                  res_valid,
  input  logic                                  res_take,
  output rrc_pkg::result_t                      res
);

  import rrc_pkg::*;

  localparam int IDX_W = $clog2(CACHE_DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(CACHE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CACHE_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_RESP
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  oldest_r;
  logic [OPCODE_W-1:0] op_r;
  logic [ID_W-1:0]   key_id_r;
  logic [CMD_W-1:0]  key_cmd_r;
  logic [SIZE_W-1:0] key_size_r;
  logic [IDX_W-1:0]  scan_addr_r;
  logic [CNT_W-1:0]  scan_i_r;
  logic              pend_r;
  logic [IDX_W-1:0]  pend_slot_r;
  result_t           res_r;

  logic [CNT_W-1:0]  tail_sum;
  logic [IDX_W-1:0]  ins_slot;
  logic              full;
  logic [IDX_W-1:0]  oldest_inc;
  logic [IDX_W-1:0]  scan_inc;
  entry_t            rd_entry;
  logic              match;

  // next free slot, oldest + count wrapped once
  assign tail_sum   = CNT_W'(oldest_r) + count_r;
  assign ins_slot   = (tail_sum >= DEPTH_C) ? IDX_W'(tail_sum - DEPTH_C) : IDX_W'(tail_sum);
  assign full       = (count_r == DEPTH_C);
  assign oldest_inc = (oldest_r == LAST_SLOT) ? '0 : oldest_r + IDX_W'(1);
  assign scan_inc   = (scan_addr_r == LAST_SLOT) ? '0 : scan_addr_r + IDX_W'(1);

  assign rd_entry = entry_t'(ram_rd_data);
  assign match    = pend_r && (rd_entry.id == key_id_r) && (rd_entry.cmd == key_cmd_r);

  assign ram_wr_en   = (state_r == S_EXEC) && (op_r == OP_INSERT);
  assign ram_wr_addr = full ? oldest_r : ins_slot;
  assign ram_wr_data = {key_id_r, key_cmd_r, key_size_r};
  assign ram_rd_en   = (state_r == S_SCAN) && (scan_i_r < count_r) && !match;
  assign ram_rd_addr = scan_addr_r;

  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_RESP);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      oldest_r <= '0;
      pend_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r       <= in_opcode;
            key_id_r   <= in_request_id;
            key_cmd_r  <= in_command_byte;
            key_size_r <= in_reply_size;
            state_r    <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (op_r)
            OP_INSERT: begin
              if (full) begin
                // drop the oldest, its slot takes the new entry
                oldest_r <= oldest_inc;
                res_r    <= {1'b0, SLOT_W'(oldest_r), SIZE_W'(0), 1'b1};
              end else begin
                count_r <= count_r + CNT_W'(1);
                res_r   <= {1'b0, SLOT_W'(ins_slot), SIZE_W'(0), 1'b0};
              end
              state_r <= S_RESP;
            end
            OP_SEARCH: begin
              scan_addr_r <= oldest_r;
              scan_i_r    <= '0;
              pend_r      <= 1'b0;
              state_r     <= S_SCAN;
            end
            OP_CLEAR: begin
              count_r  <= '0;
              oldest_r <= '0;
              res_r    <= '0;
              state_r  <= S_RESP;
            end
            default: begin
              res_r   <= '0;
              state_r <= S_RESP;
            end
          endcase
        end
        S_SCAN: begin
          if (match) begin
            res_r.hit        <= 1'b1;
            res_r.slot       <= SLOT_W'(pend_slot_r);
            res_r.found_size <= rd_entry.size;
            res_r.evicted    <= 1'b0;
            pend_r           <= 1'b0;
            state_r          <= S_RESP;
          end else if ((scan_i_r == count_r) && !pend_r) begin
            res_r   <= '0;
            state_r <= S_RESP;
          end else begin
            pend_r <= ram_rd_en;
            if (ram_rd_en) begin
              pend_slot_r <= scan_addr_r;
              scan_addr_r <= scan_inc;
              scan_i_r    <= scan_i_r + CNT_W'(1);
            end
          end
        end
        S_RESP: begin
          if (res_take) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/reply_replay_cache_top.sv
// ----------------------------------------------------------------------------
// reply_replay_cache_top: replay cache of recent replies, oldest-first eviction
// insert/clear: an accepted request passes the exec state, then the resp state
// holds its result until the output register takes it; search over n valid
// entries: the scan reads one entry of the entry ram per cycle, oldest first,
// until a match or all n are read; a new request is taken only when idle again
// reset (rst_n low, synchronous): table empty, pointers zero, no beat pending
// ----------------------------------------------------------------------------
`include "reply_replay_cache_top_defines.svh"

module reply_replay_cache_top #(
  parameter int CACHE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rrc_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [rrc_pkg::ID_W-1:0]      in_request_id,
  input  logic [rrc_pkg::CMD_W-1:0]     in_command_byte,
  input  logic [rrc_pkg::SIZE_W-1:0]    in_reply_size,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic [rrc_pkg::SLOT_W-1:0]    out_slot,
  output logic [rrc_pkg::SIZE_W-1:0]    out_found_size,
  output logic                          out_evicted
);

  import rrc_pkg::*;

  localparam int IDX_W   = $clog2(CACHE_DEPTH);
  localparam int ENTRY_W = $bits(entry_t);

  // entry ram ports
  logic               ram_wr_en;
  logic [IDX_W-1:0]   ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [IDX_W-1:0]   ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;

  // result handoff from the sequencer into the output register
  logic    res_valid;
  logic    res_take;
  result_t res;

  // output register
  logic    out_valid_r;
  result_t out_res_r;

  // id, command and size of every slot live in one ram word
  rrc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CACHE_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // pointers, insert/clear and the oldest-to-newest scan
  rrc_seq #(
    .CACHE_DEPTH (CACHE_DEPTH)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_request_id   (in_request_id),
    .in_command_byte (in_command_byte),
    .in_reply_size   (in_reply_size),
    .ram_wr_en       (ram_wr_en),
    .ram_wr_addr     (ram_wr_addr),
    .ram_wr_data     (ram_wr_data),
    .ram_rd_en       (ram_rd_en),
    .ram_rd_addr     (ram_rd_addr),
    .ram_rd_data     (ram_rd_data),
    .res_valid       (res_valid),
    .res_take        (res_take),
    .res             (res)
  );

  // the output register frees the sequencer: a finished result moves here
  // whenever the register is empty or its beat leaves this cycle, so the
  // next request can be taken while the downstream side stalls
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload holds while stalled, no reset needed
  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_res_r.hit;
  assign out_slot       = out_res_r.slot;
  assign out_found_size = out_res_r.found_size;
  assign out_evicted    = out_res_r.evicted;

  // a hit only comes from a search, eviction only from an insert
  `RRC_ASSERT_NOW(a_hit_not_evicted, out_valid && out_hit, !out_evicted)
  // a beat without a hit carries no size
  `RRC_ASSERT_NOW(a_miss_no_size, out_valid && !out_hit, out_found_size == '0)
  // an accepted request keeps the sequencer busy in the following cycle
  `RRC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // no request is taken while a result still sits in the sequencer
  `RRC_ASSERT_NOW(a_no_accept_with_result, res_valid, in_stall)

endmodule
